// File: rtl/core/assert_macros.svh
// Assertion helpers for the Q-learning table engine.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define QLTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qlte check failed");
`define QLTE_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("qlte forbidden condition");
`else
`define QLTE_ASSERT(lbl, prop)
`define QLTE_ASSERT_NEVER(lbl, expr)
`endif

`endif

// File: rtl/core/qlte_pkg.sv
`default_nettype none

package qlte_pkg;

  // Table geometry and value format
  localparam int STATE_BITS  = 16;
  localparam int NUM_ACTIONS = 4;
  localparam int VALUE_BITS  = 32;
  localparam int ACT_BITS    = (NUM_ACTIONS > 2) ? $clog2(NUM_ACTIONS) : 1;

  // Fixed field widths at the ports
  localparam int STATE_IN_W  = 16;
  localparam int ACT_IN_W    = 2;
  localparam int REWARD_W    = 12;
  localparam int DRAW_W      = 16;
  localparam int GAIN_W      = 8;
  localparam int THRESH_W    = 17;
  localparam int OUT_ACT_W   = 2;
  localparam int OUT_VALUE_W = 32;

  // Stream and config port widths
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  // Update arithmetic widths; reward*256 needs 20 bits on its own
  localparam int WIDE_BITS = (VALUE_BITS > 20) ? VALUE_BITS : 20;
  localparam int DISC_W    = VALUE_BITS + 1;
  localparam int PROD1_W   = VALUE_BITS + GAIN_W + 1;
  localparam int DELTA_W   = WIDE_BITS + 3;
  localparam int PROD2_W   = DELTA_W + GAIN_W + 1;
  localparam int INC_W     = DELTA_W;
  localparam int SUM_W     = DELTA_W + 1;
  localparam int ROUND_C   = 128;
  localparam int FRAC_BITS = 8;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Reset values of the config registers
  localparam logic [GAIN_W-1:0]   STEP_GAIN_RST     = GAIN_W'(128);
  localparam logic [GAIN_W-1:0]   FUTURE_WEIGHT_RST = GAIN_W'(230);
  localparam logic [THRESH_W-1:0] EXPLORE_THR_RST   = THRESH_W'(65536);

  typedef enum logic {
    OP_CHOOSE = 1'b0,
    OP_UPDATE = 1'b1
  } qlte_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_GAIN         = 2'd0,
    CFG_FUTURE_WEIGHT     = 2'd1,
    CFG_EXPLORE_THRESHOLD = 2'd2
  } qlte_cfg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DISC,
    ST_DELTA,
    ST_INC,
    ST_DONE
  } qlte_state_e;

  // One classified request as it sits in the queue
  typedef struct packed {
    qlte_op_e                   op;
    logic [STATE_BITS-1:0]      row;
    logic [STATE_BITS-1:0]      next_row;
    logic [ACT_BITS-1:0]        act;
    logic signed [REWARD_W-1:0] reward;
    logic [DRAW_W-1:0]          draw;
    logic [ACT_BITS-1:0]        rand_act;
  } qlte_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   step_gain;
    logic [GAIN_W-1:0]   future_weight;
    logic [THRESH_W-1:0] explore_threshold;
  } qlte_cfg_t;

  // Status from the back end
  typedef struct packed {
    logic clearing;
    logic pop;
    logic out_load;
  } qlte_back_stat_t;

  // Action code reduced modulo the number of actions (input is below 2*NUM_ACTIONS)
  function automatic logic [ACT_BITS-1:0] wrap_action(input logic [ACT_IN_W-1:0] a);
    logic [3:0] w;
    w = 4'(a);
    if (w >= 4'(NUM_ACTIONS)) begin
      w = w - 4'(NUM_ACTIONS);
    end
    return ACT_BITS'(w);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/qlte_front.sv
`default_nettype none

// Front end: takes stream transactions, decodes and pushes them into the queue.
module qlte_front (
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: state_index[15:0], next_state_index[31:16], action[33:32],
  //        reward[45:34], random_draw[61:46], random_action[63:62]
  input  wire logic [qlte_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // tuser: opcode[0]
  input  wire logic [qlte_pkg::IN_TUSER_W-1:0] s_axis_tuser,
  input  wire logic                            clearing_i,
  input  wire logic                            q_full_i,
  output logic                                 push_o,
  output qlte_pkg::qlte_item_t                 item_o
);

  // No transactions while the table clear runs or the queue is full
  assign s_axis_tready = !q_full_i && !clearing_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  // Field decode: rows keep their low bits, actions wrap
  always_comb begin
    item_o.op       = qlte_pkg::qlte_op_e'(s_axis_tuser[0]);
    item_o.row      = qlte_pkg::STATE_BITS'(s_axis_tdata[15:0]);
    item_o.next_row = qlte_pkg::STATE_BITS'(s_axis_tdata[31:16]);
    item_o.act      = qlte_pkg::wrap_action(s_axis_tdata[33:32]);
    item_o.reward   = $signed(s_axis_tdata[45:34]);
    item_o.draw     = s_axis_tdata[61:46];
    item_o.rand_act = qlte_pkg::wrap_action(s_axis_tdata[63:62]);
  end

endmodule

`default_nettype wire

// File: rtl/core/qlte_queue.sv
`default_nettype none

// Short FIFO between decode and execution.
module qlte_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  qlte_pkg::qlte_item_t      item_i,
  input  wire logic                 pop_i,
  output qlte_pkg::qlte_item_t      head_o,
  output logic                      full_o,
  output logic                      empty_o
);

  qlte_pkg::qlte_item_t             slot_q [qlte_pkg::QUEUE_DEPTH];
  logic [qlte_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [qlte_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [qlte_pkg::QPTR_W:0]        cnt_q, cnt_d;

  assign full_o  = (cnt_q == (qlte_pkg::QPTR_W+1)'(qlte_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/qlte_back.sv
`default_nettype none

// Back end: value table, row scan, update arithmetic and result register.
module qlte_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  qlte_pkg::qlte_cfg_t                   cfg_i,
  input  qlte_pkg::qlte_item_t                  item_i,
  input  wire logic                             empty_i,
  output qlte_pkg::qlte_back_stat_t             stat_o,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: chosen_action[1:0], new_value[33:2], zero fill[39:34]
  output logic [qlte_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // tuser: explored[0], saturated[1]
  output logic [qlte_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

  localparam int SB = qlte_pkg::STATE_BITS;
  localparam int NA = qlte_pkg::NUM_ACTIONS;
  localparam int VB = qlte_pkg::VALUE_BITS;
  localparam int AB = qlte_pkg::ACT_BITS;
  localparam int ROWS = 2 ** SB;

  localparam logic signed [qlte_pkg::SUM_W-1:0] V_MAX =
    {{(qlte_pkg::SUM_W-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [qlte_pkg::SUM_W-1:0] V_MIN = ~V_MAX;

  // Value table, one row of NA entries per state, cleared by a sweep after reset
  logic [NA-1:0][VB-1:0] tbl_mem [ROWS];

  qlte_pkg::qlte_state_e state_q, state_d;
  logic [SB-1:0]         clr_row_q, clr_row_d;

  qlte_pkg::qlte_item_t  item_q;
  logic [NA-1:0][VB-1:0] rd_a_q, rd_b_q;
  logic [AB-1:0]         scan_k_q;
  logic signed [VB-1:0]  best_a_q, best_b_q;
  logic [AB-1:0]         idx_a_q;
  logic signed [qlte_pkg::DISC_W-1:0]  disc_q;
  logic signed [qlte_pkg::DELTA_W-1:0] delta_q;
  logic signed [qlte_pkg::INC_W-1:0]   inc_q;

  logic                                out_valid_q;
  logic [qlte_pkg::OUT_ACT_W-1:0]      out_act_q;
  logic                                out_expl_q;
  logic [qlte_pkg::OUT_VALUE_W-1:0]    out_val_q;
  logic                                out_sat_q;

  logic pop, clr_we, upd_we, out_load, scan_last, out_free;

  logic signed [VB-1:0]                q_cur;
  logic signed [VB-1:0]                lane_a, lane_b;
  logic signed [qlte_pkg::PROD1_W-1:0] disc_prod;
  logic signed [qlte_pkg::DISC_W-1:0]  disc_d;
  logic signed [qlte_pkg::DELTA_W-1:0] delta_d;
  logic signed [qlte_pkg::PROD2_W-1:0] inc_prod;
  logic signed [qlte_pkg::INC_W-1:0]   inc_d;
  logic signed [qlte_pkg::SUM_W-1:0]   sum;
  logic signed [VB-1:0]                nv_val;
  logic                                nv_sat;
  logic                                explore;
  logic [AB-1:0]                       pick;

  assign scan_last = (scan_k_q == AB'(NA-1));

  // Result register can take a new transaction this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      qlte_pkg::ST_CLEAR: begin
        if (clr_row_q == '1) state_d = qlte_pkg::ST_IDLE;
      end
      qlte_pkg::ST_IDLE: begin
        if (!empty_i) state_d = qlte_pkg::ST_FIRST;
      end
      qlte_pkg::ST_FIRST: state_d = qlte_pkg::ST_SCAN;
      qlte_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = (item_q.op == qlte_pkg::OP_UPDATE) ? qlte_pkg::ST_DISC
                                                       : qlte_pkg::ST_DONE;
        end
      end
      qlte_pkg::ST_DISC:  state_d = qlte_pkg::ST_DELTA;
      qlte_pkg::ST_DELTA: state_d = qlte_pkg::ST_INC;
      qlte_pkg::ST_INC:   state_d = qlte_pkg::ST_DONE;
      qlte_pkg::ST_DONE: begin
        // hold the finished item while the previous result waits
        if (out_free) state_d = qlte_pkg::ST_IDLE;
      end
      default:            state_d = qlte_pkg::ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    pop      = 1'b0;
    clr_we   = 1'b0;
    upd_we   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      qlte_pkg::ST_CLEAR: clr_we = 1'b1;
      qlte_pkg::ST_IDLE:  pop = !empty_i;
      qlte_pkg::ST_DONE: begin
        out_load = out_free;
        upd_we   = out_free && (item_q.op == qlte_pkg::OP_UPDATE);
      end
      default: ;
    endcase
  end

  assign stat_o.clearing = clr_we;
  assign stat_o.pop      = pop;
  assign stat_o.out_load = out_load;

  assign clr_row_d = clr_we ? clr_row_q + 1'b1 : clr_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qlte_pkg::ST_CLEAR;
      clr_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_row_q <= clr_row_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Table port: one write (clear sweep or update), two registered row reads
  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      tbl_mem[clr_row_q] <= '0;
    end else if (upd_we) begin
      tbl_mem[item_q.row][item_q.act] <= nv_val;
    end
    if (pop) begin
      rd_a_q <= tbl_mem[item_i.row];
      rd_b_q <= tbl_mem[item_i.next_row];
    end
  end

  // Lanes under the scan pointer, and the entry being updated
  assign lane_a = $signed(rd_a_q[scan_k_q]);
  assign lane_b = $signed(rd_b_q[scan_k_q]);
  assign q_cur  = $signed(rd_a_q[item_q.act]);

  // disc = floor((gamma * best + 128) / 256)
  assign disc_prod = qlte_pkg::PROD1_W'(signed'({1'b0, cfg_i.future_weight}))
                   * qlte_pkg::PROD1_W'(best_b_q)
                   + qlte_pkg::PROD1_W'(qlte_pkg::ROUND_C);
  assign disc_d = qlte_pkg::DISC_W'(disc_prod >>> qlte_pkg::FRAC_BITS);

  // delta = reward * 256 + disc - q
  assign delta_d = (qlte_pkg::DELTA_W'($signed(item_q.reward)) <<< qlte_pkg::FRAC_BITS)
                 + qlte_pkg::DELTA_W'(disc_q)
                 - qlte_pkg::DELTA_W'(q_cur);

  // inc = floor((lr * delta + 128) / 256)
  assign inc_prod = qlte_pkg::PROD2_W'(signed'({1'b0, cfg_i.step_gain}))
                  * qlte_pkg::PROD2_W'(delta_q)
                  + qlte_pkg::PROD2_W'(qlte_pkg::ROUND_C);
  assign inc_d = qlte_pkg::INC_W'(inc_prod >>> qlte_pkg::FRAC_BITS);

  // New value with saturation
  always_comb begin
    sum    = qlte_pkg::SUM_W'(q_cur) + qlte_pkg::SUM_W'(inc_q);
    nv_sat = 1'b0;
    if (sum > V_MAX) begin
      nv_val = VB'(V_MAX);
      nv_sat = 1'b1;
    end else if (sum < V_MIN) begin
      nv_val = VB'(V_MIN);
      nv_sat = 1'b1;
    end else begin
      nv_val = VB'(sum);
    end
  end

  // Epsilon-greedy pick for choose
  assign explore = (qlte_pkg::THRESH_W'(item_q.draw) < cfg_i.explore_threshold);
  assign pick    = explore ? item_q.rand_act : idx_a_q;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q <= item_i;
    end
    case (state_q)
      qlte_pkg::ST_FIRST: begin
        best_a_q <= $signed(rd_a_q[0]);
        best_b_q <= $signed(rd_b_q[0]);
        idx_a_q  <= '0;
        scan_k_q <= AB'(1);
      end
      qlte_pkg::ST_SCAN: begin
        // strict compare keeps the first maximum
        if (lane_a > best_a_q) begin
          best_a_q <= lane_a;
          idx_a_q  <= scan_k_q;
        end
        if (lane_b > best_b_q) begin
          best_b_q <= lane_b;
        end
        scan_k_q <= scan_k_q + 1'b1;
      end
      qlte_pkg::ST_DISC:  disc_q  <= disc_d;
      qlte_pkg::ST_DELTA: delta_q <= delta_d;
      qlte_pkg::ST_INC:   inc_q   <= inc_d;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (item_q.op == qlte_pkg::OP_UPDATE) begin
        out_act_q  <= qlte_pkg::OUT_ACT_W'(item_q.act);
        out_expl_q <= 1'b0;
        out_val_q  <= qlte_pkg::OUT_VALUE_W'(nv_val);
        out_sat_q  <= nv_sat;
      end else begin
        out_act_q  <= qlte_pkg::OUT_ACT_W'(pick);
        out_expl_q <= explore;
        out_val_q  <= qlte_pkg::OUT_VALUE_W'(best_a_q);
        out_sat_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = qlte_pkg::OUT_TDATA_W'({out_val_q, out_act_q});
  assign m_axis_tuser  = {out_sat_q, out_expl_q};

endmodule

`default_nettype wire

// File: rtl/core/q_learning_table_engine_core.sv
// Q-learning table engine, epsilon-greedy choose and saturating value update.
// Each item is decoded into the queue; the back end then reads its rows, scans them one
// lane per cycle, and for update runs the discount, delta and increment steps in turn.
// The back end finishes one item before it takes the next; the two-entry queue holds
// further items meanwhile, and a finished item waits while the result is not taken.
// Reset: a sweep zeroes every row; inputs wait for it, config writes do not.
`default_nettype none
`include "assert_macros.svh"

module q_learning_table_engine_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: state_index[15:0], next_state_index[31:16], action[33:32],
  //        reward[45:34], random_draw[61:46], random_action[63:62]
  input  wire logic [qlte_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: opcode[0]
  input  wire logic [qlte_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: chosen_action[1:0], new_value[33:2], zero fill[39:34]
  output logic [qlte_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // tuser: explored[0], saturated[1]
  output logic [qlte_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
  input  wire logic                             cfg_we_i,
  input  wire logic [qlte_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [qlte_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  qlte_pkg::qlte_cfg_t       cfg_q;
  qlte_pkg::qlte_item_t      front_item, q_head;
  qlte_pkg::qlte_back_stat_t back_stat;
  logic                      push, q_full, q_empty;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_gain         <= qlte_pkg::STEP_GAIN_RST;
      cfg_q.future_weight     <= qlte_pkg::FUTURE_WEIGHT_RST;
      cfg_q.explore_threshold <= qlte_pkg::EXPLORE_THR_RST;
    end else if (cfg_we_i) begin
      case (qlte_pkg::qlte_cfg_e'(cfg_index_i))
        qlte_pkg::CFG_STEP_GAIN:
          cfg_q.step_gain <= qlte_pkg::GAIN_W'(cfg_data_i);
        qlte_pkg::CFG_FUTURE_WEIGHT:
          cfg_q.future_weight <= qlte_pkg::GAIN_W'(cfg_data_i);
        qlte_pkg::CFG_EXPLORE_THRESHOLD:
          cfg_q.explore_threshold <= qlte_pkg::THRESH_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  qlte_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clearing_i    (back_stat.clearing),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (front_item)
  );

  qlte_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (back_stat.pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  qlte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_i        (q_head),
    .empty_i       (q_empty),
    .stat_o        (back_stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Checks
  `QLTE_ASSERT(a_no_accept_in_clear, back_stat.clearing |-> !s_axis_tready)
  `QLTE_ASSERT(a_pop_needs_entry, back_stat.pop |-> !q_empty)
  `QLTE_ASSERT(a_load_into_free_out, back_stat.out_load |-> (!m_axis_tvalid || m_axis_tready))
  `QLTE_ASSERT_NEVER(a_explore_sat_excl, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1])

endmodule

`default_nettype wire
